[hdl/json_token_lexer_core_defines.svh]
// assertion helpers for the json lexer
`ifndef JSON_TOKEN_LEXER_CORE_DEFINES_SVH
`define JSON_TOKEN_LEXER_CORE_DEFINES_SVH

// condition holds on every clock edge out of reset
`define JTL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define JTL_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define JTL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[hdl/jtl_pkg.sv]
`default_nettype none
package jtl_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  localparam logic [3:0] KIND_OBJ_OPEN  = 4'd0;
  localparam logic [3:0] KIND_OBJ_CLOSE = 4'd1;
  localparam logic [3:0] KIND_ARR_OPEN  = 4'd2;
  localparam logic [3:0] KIND_ARR_CLOSE = 4'd3;
  localparam logic [3:0] KIND_SEP       = 4'd4;
  localparam logic [3:0] KIND_NUMBER    = 4'd5;
  localparam logic [3:0] KIND_PRIM      = 4'd6;
  localparam logic [3:0] KIND_STRING    = 4'd7;
  localparam logic [3:0] KIND_UNKNOWN   = 4'd8;

  localparam logic [1:0] WSEL_TRUE  = 2'd0;
  localparam logic [1:0] WSEL_FALSE = 2'd1;
  localparam logic [1:0] WSEL_NULL  = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] value;
    logic       has;
    logic       first;
    logic       last;
    logic       err;
    logic       done;
    logic       run_last;
  } res_t;

  function automatic res_t mk_res(logic [3:0] kind, logic [7:0] value, logic has,
                                  logic first, logic last, logic err, logic done);
    res_t r;
    r.kind     = kind;
    r.value    = value;
    r.has      = has;
    r.first    = first;
    r.last     = last;
    r.err      = err;
    r.done     = done;
    r.run_last = 1'b0;
    return r;
  endfunction

  function automatic logic [2:0] word_len(logic [1:0] sel);
    logic [2:0] n;
    n = (sel == WSEL_FALSE) ? 3'd5 : 3'd4;
    return n;
  endfunction

  function automatic logic [7:0] word_char(logic [1:0] sel, logic [2:0] pos);
    logic [7:0] ch;
    ch = CH_NUL;
    unique case (sel)
      WSEL_TRUE: begin
        unique case (pos)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = CH_NUL;
        endcase
      end
      WSEL_FALSE: begin
        unique case (pos)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = CH_NUL;
        endcase
      end
      default: begin
        unique case (pos)
          3'd0: ch = "n";
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ch = CH_NUL;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

[hdl/json_token_lexer_core.sv]
// json_token_lexer_core
// streaming JSON lexer, one text byte per input transaction, byte 0 ends the text.
// input channel: in_valid / in_stall / in_text_byte. output channel: out_valid /
// out_stall and one port per result field; each output transaction is one token
// character or marker, tagged with kind, first/last marks and error/done flags.
// a byte yields zero, one or two results (two when the byte that ends a number
// also starts a token, ends the text or fails, or for a two-character escape).
// the results of a byte are registered in the result queue when the byte is
// accepted and are offered from its head. a byte is taken every cycle while the
// 4-entry result queue has room for two results; with one result per byte and
// no stall the rate is one byte per cycle.
// a stalled receiver holds the queue head steady; the queue then fills and
// in_stall rises once fewer than two free entries remain.
// reset (synchronous, rst_n low) empties the queue and returns the lexer to
// idle between tokens. after a lexing error the block drops every byte until
// the end of text, which then yields one done result.
`default_nettype none
`include "json_token_lexer_core_defines.svh"
module json_token_lexer_core
  import jtl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_text_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      out_token_kind,
  output logic [7:0]      out_value_byte,
  output logic            out_has_byte,
  output logic            out_token_first,
  output logic            out_token_last,
  output logic            out_lex_error,
  output logic            out_text_done,
  output logic            out_last_of_run
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MINUS, ST_ZERO, ST_INT, ST_DOT, ST_FRAC, ST_WORD, ST_STR, ST_ESC, ST_HALT
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [1:0]       sel_r, sel_nxt;
  logic [2:0]       pos_r, pos_nxt;

  res_t             fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             in_acc, out_acc;
  logic [7:0]       c;
  logic             is_dig;
  logic [1:0]       push_n;
  res_t             r0, r1;

  // idle-side token start, also used right after a number closes
  logic             idle_emit, idle_word;
  res_t             idle_res;
  mode_t            idle_mode;
  logic [1:0]       idle_sel;

  res_t             fail_res, end_res, num_res, close_res;
  mode_t            fail_mode;
  logic [2:0]       pos_inc;
  logic [1:0]       close_n;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign in_stall = (cnt_r > CNT_W'(FIFO_DEPTH - 2));
  assign c        = in_text_byte;
  assign is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);
  assign pos_inc  = pos_r + 3'd1;

  always_comb begin
    fail_res  = mk_res(KIND_UNKNOWN, CH_NUL, 1'b0, 1'b1, 1'b1, 1'b1, c == CH_NUL);
    fail_mode = (c == CH_NUL) ? ST_IDLE : ST_HALT;
    end_res   = mk_res(KIND_UNKNOWN, CH_NUL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    num_res   = mk_res(KIND_NUMBER, c, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    close_res = mk_res(KIND_NUMBER, CH_NUL, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
  end

  always_comb begin
    idle_emit = 1'b1;
    idle_word = 1'b0;
    idle_sel  = WSEL_TRUE;
    idle_mode = ST_IDLE;
    idle_res  = mk_res(KIND_SEP, c, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    unique case (c)
      CH_NUL: idle_res = end_res;
      8'h20, 8'h09, 8'h0A, 8'h0D: idle_emit = 1'b0;
      "{": idle_res.kind = KIND_OBJ_OPEN;
      "}": idle_res.kind = KIND_OBJ_CLOSE;
      "[": idle_res.kind = KIND_ARR_OPEN;
      "]": idle_res.kind = KIND_ARR_CLOSE;
      ",", ":": idle_res.kind = KIND_SEP;
      CH_MINUS: begin
        idle_res  = mk_res(KIND_NUMBER, c, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        idle_mode = ST_MINUS;
      end
      "t", "f", "n": begin
        idle_res  = mk_res(KIND_PRIM, c, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        idle_mode = ST_WORD;
        idle_word = 1'b1;
        idle_sel  = (c == "t") ? WSEL_TRUE : ((c == "f") ? WSEL_FALSE : WSEL_NULL);
      end
      CH_QUOTE: begin
        idle_res  = mk_res(KIND_STRING, CH_NUL, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        idle_mode = ST_STR;
      end
      default: begin
        if (is_dig) begin
          idle_res  = mk_res(KIND_NUMBER, c, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
          idle_mode = (c == CH_ZERO) ? ST_ZERO : ST_INT;
        end else begin
          idle_res  = fail_res;
          idle_mode = fail_mode;
        end
      end
    endcase
  end

  always_comb begin
    close_n  = idle_emit ? 2'd2 : 2'd1;
    push_n   = 2'd0;
    r0       = fail_res;
    r1       = idle_res;
    mode_nxt = mode_r;
    sel_nxt  = sel_r;
    pos_nxt  = pos_r;
    unique case (mode_r)
      ST_MINUS: begin
        push_n = 2'd1;
        if (is_dig) begin
          r0       = num_res;
          mode_nxt = (c == CH_ZERO) ? ST_ZERO : ST_INT;
        end else begin
          mode_nxt = fail_mode;
        end
      end
      ST_ZERO, ST_INT, ST_FRAC: begin
        if (is_dig && mode_r != ST_ZERO) begin
          push_n = 2'd1;
          r0     = num_res;
        end else if (c == CH_DOT && mode_r != ST_FRAC) begin
          push_n   = 2'd1;
          r0       = num_res;
          mode_nxt = ST_DOT;
        end else begin
          push_n   = close_n;
          r0       = close_res;
          mode_nxt = idle_mode;
          if (idle_word) begin
            sel_nxt = idle_sel;
            pos_nxt = 3'd1;
          end
        end
      end
      ST_DOT: begin
        push_n = 2'd1;
        if (is_dig) begin
          r0       = num_res;
          mode_nxt = ST_FRAC;
        end else begin
          mode_nxt = fail_mode;
        end
      end
      ST_WORD: begin
        push_n = 2'd1;
        if (pos_r < word_len(sel_r) && c == word_char(sel_r, pos_r)) begin
          r0 = mk_res(KIND_PRIM, c, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
          if (pos_inc >= word_len(sel_r)) begin
            r0.last  = 1'b1;
            mode_nxt = ST_IDLE;
            pos_nxt  = 3'd0;
          end else begin
            pos_nxt = pos_inc;
          end
        end else begin
          pos_nxt  = 3'd0;
          mode_nxt = fail_mode;
        end
      end
      ST_STR: begin
        priority if (c == CH_NUL) begin
          push_n   = 2'd1;
          mode_nxt = fail_mode;
        end else if (c == CH_QUOTE) begin
          push_n   = 2'd1;
          r0       = mk_res(KIND_STRING, CH_NUL, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
          mode_nxt = ST_IDLE;
        end else if (c == CH_BSLASH) begin
          mode_nxt = ST_ESC;
        end else begin
          push_n = 2'd1;
          r0     = mk_res(KIND_STRING, c, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        end
      end
      ST_ESC: begin
        if (c == CH_BSLASH || c == CH_QUOTE || c == CH_SLASH) begin
          push_n   = 2'd1;
          r0       = mk_res(KIND_STRING, c, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
          mode_nxt = ST_STR;
        end else if (c == "b" || c == "f" || c == "n" || c == "r" ||
                     c == "t" || c == "u") begin
          push_n   = 2'd2;
          r0       = mk_res(KIND_STRING, CH_BSLASH, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
          r1       = mk_res(KIND_STRING, c, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
          mode_nxt = ST_STR;
        end else begin
          push_n   = 2'd1;
          mode_nxt = fail_mode;
        end
      end
      ST_HALT: begin
        if (c == CH_NUL) begin
          push_n   = 2'd1;
          r0       = end_res;
          mode_nxt = ST_IDLE;
        end
      end
      default: begin
        push_n   = idle_emit ? 2'd1 : 2'd0;
        r0       = idle_res;
        mode_nxt = idle_mode;
        if (idle_word) begin
          sel_nxt = idle_sel;
          pos_nxt = 3'd1;
        end
      end
    endcase
    if (push_n == 2'd1) begin
      r0.run_last = 1'b1;
    end
    if (push_n == 2'd2) begin
      r1.run_last = 1'b1;
    end
  end

  assign cnt_nxt = cnt_r + (in_acc ? CNT_W'(push_n) : CNT_W'(0)) - CNT_W'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ST_IDLE;
      sel_r  <= WSEL_TRUE;
      pos_r  <= 3'd0;
      wr_r   <= '0;
      rd_r   <= '0;
      cnt_r  <= '0;
    end else begin
      if (in_acc) begin
        mode_r <= mode_nxt;
        sel_r  <= sel_nxt;
        pos_r  <= pos_nxt;
        wr_r   <= wr_r + PTR_W'(push_n);
      end
      if (out_acc) begin
        rd_r <= rd_r + PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && push_n != 2'd0) begin
      fifo_r[wr_r] <= r0;
    end
    if (in_acc && push_n == 2'd2) begin
      fifo_r[wr_r + PTR_W'(1)] <= r1;
    end
  end

  assign out_valid       = (cnt_r != '0);
  assign out_token_kind  = fifo_r[rd_r].kind;
  assign out_value_byte  = fifo_r[rd_r].value;
  assign out_has_byte    = fifo_r[rd_r].has;
  assign out_token_first = fifo_r[rd_r].first;
  assign out_token_last  = fifo_r[rd_r].last;
  assign out_lex_error   = fifo_r[rd_r].err;
  assign out_text_done   = fifo_r[rd_r].done;
  assign out_last_of_run = fifo_r[rd_r].run_last;

  `JTL_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(FIFO_DEPTH), "result queue overflow")
  `JTL_ASSERT_IMPL(a_err_marks, out_valid && out_lex_error,
    out_token_first && out_token_last && !out_has_byte, "error transaction marks wrong")
  `JTL_ASSERT_IMPL(a_done_ends_run, out_valid && out_text_done, out_last_of_run,
    "done transaction not last of run")
  `JTL_ASSERT_NEXT(a_halt_quiet, in_acc && mode_r == ST_HALT && c != CH_NUL,
    mode_r == ST_HALT && cnt_r <= $past(cnt_r), "halted lexer produced a result")

endmodule
`default_nettype wire

[sim/json_token_lexer_core_tb.sv]
`timescale 1ns / 1ps
module json_token_lexer_core_tb;
  import jtl_pkg::*;

  localparam int ITEM_TARGET = 420;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 20;

  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  typedef enum logic [3:0] {
    LX_IDLE, LX_MINUS, LX_ZERO, LX_INT, LX_DOT, LX_FRAC, LX_WORD, LX_STR, LX_ESC, LX_HALT
  } lex_mode_e;

  typedef enum int {GT_PUNCT, GT_NUMBER, GT_WORD, GT_STRING} gen_token_e;
  typedef enum int {
    BR_BAD_START, BR_MINUS, BR_DOT, BR_WORD, BR_ESCAPE, BR_OPEN_STR
  } gen_broken_e;
  typedef enum int {ST_NONE, ST_LIGHT, ST_HEAVY, ST_PERIODIC} stall_pat_e;

  typedef struct {
    logic [7:0] ch;
    bit         drain;
  } text_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_text_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] out_token_kind;
  logic [7:0] out_value_byte;
  logic       out_has_byte;
  logic       out_token_first;
  logic       out_token_last;
  logic       out_lex_error;
  logic       out_text_done;
  logic       out_last_of_run;

  json_token_lexer_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_token_kind  (out_token_kind),
    .out_value_byte  (out_value_byte),
    .out_has_byte    (out_has_byte),
    .out_token_first (out_token_first),
    .out_token_last  (out_token_last),
    .out_lex_error   (out_lex_error),
    .out_text_done   (out_text_done),
    .out_last_of_run (out_last_of_run)
  );

  always #6 clk = ~clk;

  string      word_tab[3] = '{"true", "false", "null"};
  string      esc_ok      = "\\\"/bfnrtu";
  string      punct       = "{}[],:";
  string      starts      = "{}[],:-tfn\"0123456789 \t\n";

  text_item_t text_q[$];
  res_t       expect_q[$];
  res_t       run_q[$];
  lex_mode_e  mode = LX_IDLE;
  logic [1:0] wsel = WSEL_TRUE;
  logic [2:0] wpos = 3'd0;

  bit         drain_next = 1'b0;
  int         n_total = 0;
  int         n_items = 0;
  int         n_texts = 0;
  int         n_accepted = 0;
  int         n_checked = 0;
  int         n_tok_ends = 0;
  int         n_lex_errs = 0;
  int         errors = 0;
  int         cycles = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  stall_pat_e stall_pat = ST_NONE;

  // expected token stream

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void add_res(logic [3:0] kind, logic [7:0] value, bit has, bit first,
                                  bit last, bit err, bit done);
    res_t r;
    r.kind     = kind;
    r.value    = value;
    r.has      = has;
    r.first    = first;
    r.last     = last;
    r.err      = err;
    r.done     = done;
    r.run_last = 1'b0;
    run_q.push_back(r);
  endfunction

  function automatic void lex_fail(logic [7:0] c);
    if (c == CH_NUL) begin
      add_res(KIND_UNKNOWN, 8'h00, 0, 1, 1, 1, 1);
      mode = LX_IDLE;
    end else begin
      add_res(KIND_UNKNOWN, 8'h00, 0, 1, 1, 1, 0);
      mode = LX_HALT;
    end
  endfunction

  function automatic void lex_start(logic [7:0] c);
    mode = LX_IDLE;
    case (c)
      CH_NUL: add_res(KIND_UNKNOWN, 8'h00, 0, 0, 0, 0, 1);
      CH_SP, CH_TAB, CH_LF, CH_CR: ;
      "{": add_res(KIND_OBJ_OPEN, c, 1, 1, 1, 0, 0);
      "}": add_res(KIND_OBJ_CLOSE, c, 1, 1, 1, 0, 0);
      "[": add_res(KIND_ARR_OPEN, c, 1, 1, 1, 0, 0);
      "]": add_res(KIND_ARR_CLOSE, c, 1, 1, 1, 0, 0);
      ",", ":": add_res(KIND_SEP, c, 1, 1, 1, 0, 0);
      CH_MINUS: begin
        add_res(KIND_NUMBER, c, 1, 1, 0, 0, 0);
        mode = LX_MINUS;
      end
      "t", "f", "n": begin
        wsel = (c == "t") ? WSEL_TRUE : ((c == "f") ? WSEL_FALSE : WSEL_NULL);
        wpos = 3'd1;
        add_res(KIND_PRIM, c, 1, 1, 0, 0, 0);
        mode = LX_WORD;
      end
      CH_QUOTE: begin
        add_res(KIND_STRING, 8'h00, 0, 1, 0, 0, 0);
        mode = LX_STR;
      end
      default: begin
        if (is_digit(c)) begin
          add_res(KIND_NUMBER, c, 1, 1, 0, 0, 0);
          mode = (c == CH_ZERO) ? LX_ZERO : LX_INT;
        end else begin
          lex_fail(c);
        end
      end
    endcase
  endfunction

  function automatic void num_close(logic [7:0] c);
    add_res(KIND_NUMBER, 8'h00, 0, 0, 1, 0, 0);
    lex_start(c);
  endfunction

  function automatic void lex_byte(logic [7:0] c);
    string wd;
    case (mode)
      LX_MINUS: begin
        if (is_digit(c)) begin
          add_res(KIND_NUMBER, c, 1, 0, 0, 0, 0);
          mode = (c == CH_ZERO) ? LX_ZERO : LX_INT;
        end else begin
          lex_fail(c);
        end
      end
      LX_ZERO: begin
        if (c == CH_DOT) begin
          add_res(KIND_NUMBER, c, 1, 0, 0, 0, 0);
          mode = LX_DOT;
        end else begin
          num_close(c);
        end
      end
      LX_INT: begin
        if (is_digit(c)) begin
          add_res(KIND_NUMBER, c, 1, 0, 0, 0, 0);
        end else if (c == CH_DOT) begin
          add_res(KIND_NUMBER, c, 1, 0, 0, 0, 0);
          mode = LX_DOT;
        end else begin
          num_close(c);
        end
      end
      LX_DOT: begin
        if (is_digit(c)) begin
          add_res(KIND_NUMBER, c, 1, 0, 0, 0, 0);
          mode = LX_FRAC;
        end else begin
          lex_fail(c);
        end
      end
      LX_FRAC: begin
        if (is_digit(c)) begin
          add_res(KIND_NUMBER, c, 1, 0, 0, 0, 0);
        end else begin
          num_close(c);
        end
      end
      LX_WORD: begin
        wd = word_tab[(wsel == 2'd3) ? WSEL_NULL : wsel];
        if (wpos < wd.len() && c == wd[wpos]) begin
          if (wpos + 1 >= wd.len()) begin
            add_res(KIND_PRIM, c, 1, 0, 1, 0, 0);
            mode = LX_IDLE;
            wpos = 3'd0;
          end else begin
            add_res(KIND_PRIM, c, 1, 0, 0, 0, 0);
            wpos = wpos + 3'd1;
          end
        end else begin
          wpos = 3'd0;
          lex_fail(c);
        end
      end
      LX_STR: begin
        if (c == CH_NUL) begin
          lex_fail(c);
        end else if (c == CH_QUOTE) begin
          add_res(KIND_STRING, 8'h00, 0, 0, 1, 0, 0);
          mode = LX_IDLE;
        end else if (c == CH_BSLASH) begin
          mode = LX_ESC;
        end else begin
          add_res(KIND_STRING, c, 1, 0, 0, 0, 0);
        end
      end
      LX_ESC: begin
        if (c == CH_BSLASH || c == CH_QUOTE || c == CH_SLASH) begin
          add_res(KIND_STRING, c, 1, 0, 0, 0, 0);
          mode = LX_STR;
        end else if (c == "b" || c == "f" || c == "n" || c == "r" || c == "t" ||
                     c == "u") begin
          add_res(KIND_STRING, CH_BSLASH, 1, 0, 0, 0, 0);
          add_res(KIND_STRING, c, 1, 0, 0, 0, 0);
          mode = LX_STR;
        end else begin
          lex_fail(c);
        end
      end
      LX_HALT: begin
        if (c == CH_NUL) begin
          add_res(KIND_UNKNOWN, 8'h00, 0, 0, 0, 0, 1);
          mode = LX_IDLE;
        end
      end
      default: lex_start(c);
    endcase
    if (run_q.size() != 0) run_q[run_q.size() - 1].run_last = 1'b1;
    foreach (run_q[i]) expect_q.push_back(run_q[i]);
    run_q.delete();
  endfunction

  // text generation

  function automatic void put(logic [7:0] ch, bit counted);
    text_item_t it;
    it.ch = ch;
    it.drain = drain_next;
    drain_next = 1'b0;
    text_q.push_back(it);
    n_total++;
    if (counted) n_items++;
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i], 1);
  endfunction

  function automatic void put_ws();
    case ($urandom_range(0, 3))
      0: put(CH_SP, 0);
      1: put(CH_TAB, 0);
      2: put(CH_LF, 0);
      default: put(CH_CR, 0);
    endcase
  endfunction

  function automatic bit in_set(string s, logic [7:0] c);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < s.len(); i++) if (s[i] == c) hit = 1'b1;
    return hit;
  endfunction

  function automatic void put_digits(int n);
    repeat (n) put(CH_ZERO + 8'($urandom_range(0, 9)), 1);
  endfunction

  function automatic void put_str_body(int n);
    logic [7:0] c;
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) begin
        put(CH_BSLASH, 1);
        put(esc_ok[$urandom_range(0, 8)], 1);
      end else begin
        do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
        put(c, 1);
      end
    end
  endfunction

  function automatic void gen_token(bit last_tok);
    gen_token_e kind;
    kind = gen_token_e'($urandom_range(0, 3));
    case (kind)
      GT_PUNCT: put(punct[$urandom_range(0, 5)], 1);
      GT_NUMBER: begin
        if ($urandom_range(0, 1) == 1) put(CH_MINUS, 1);
        if ($urandom_range(0, 3) == 0) begin
          put(CH_ZERO, 1);
        end else begin
          put(CH_ZERO + 8'($urandom_range(1, 9)), 1);
          put_digits($urandom_range(0, 3));
        end
        if ($urandom_range(0, 2) == 0) begin
          put(CH_DOT, 1);
          put_digits($urandom_range(1, 3));
        end
        if (!last_tok) begin
          case ($urandom_range(0, 3))
            0: put(",", 1);
            1: put("]", 1);
            2: put("}", 1);
            default: put_ws();
          endcase
        end
      end
      GT_WORD: put_str(word_tab[$urandom_range(0, 2)]);
      default: begin
        put(CH_QUOTE, 1);
        put_str_body($urandom_range(0, 6));
        put(CH_QUOTE, 1);
      end
    endcase
    if ($urandom_range(0, 2) == 0) put_ws();
  endfunction

  // returns 1 when the failing byte already ended the text
  function automatic bit gen_broken();
    gen_broken_e kind;
    logic [7:0]  c;
    string       wd;
    int          pos;
    kind = gen_broken_e'($urandom_range(0, 5));
    case (kind)
      BR_BAD_START: begin
        do c = 8'($urandom_range(1, 255)); while (in_set(starts, c) || c == CH_CR);
      end
      BR_MINUS: begin
        put(CH_MINUS, 1);
        do c = 8'($urandom_range(0, 255)); while (is_digit(c));
      end
      BR_DOT: begin
        if ($urandom_range(0, 1) == 1) put(CH_MINUS, 1);
        put_digits($urandom_range(1, 3));
        put(CH_DOT, 1);
        do c = 8'($urandom_range(0, 255)); while (is_digit(c));
      end
      BR_WORD: begin
        wd = word_tab[$urandom_range(0, 2)];
        pos = $urandom_range(1, wd.len() - 1);
        for (int i = 0; i < pos; i++) put(wd[i], 1);
        do c = 8'($urandom_range(0, 255)); while (c == wd[pos]);
      end
      BR_ESCAPE: begin
        put(CH_QUOTE, 1);
        put_str_body($urandom_range(0, 3));
        put(CH_BSLASH, 1);
        do c = 8'($urandom_range(0, 255)); while (in_set(esc_ok, c));
      end
      default: begin
        put(CH_QUOTE, 1);
        put_str_body($urandom_range(0, 3));
        if ($urandom_range(0, 2) == 0) put(CH_BSLASH, 1);
        c = CH_NUL;
      end
    endcase
    put(c, 1);
    return c == CH_NUL;
  endfunction

  function automatic void gen_text();
    int ntok;
    bit broken;
    int brk_at;
    ntok = $urandom_range(1, 8);
    broken = ($urandom_range(0, 3) == 0);
    brk_at = $urandom_range(0, ntok - 1);
    if ($urandom_range(0, 7) == 0) drain_next = 1'b1;
    for (int t = 0; t < ntok; t++) begin
      if (broken && t == brk_at) begin
        if (gen_broken()) return;
        repeat ($urandom_range(0, 3)) put(8'($urandom_range(1, 255)), 0);
        put(CH_NUL, 1);
        return;
      end
      gen_token(t == ntok - 1);
    end
    put(CH_NUL, 1);
  endfunction

  // sender

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        lex_byte(in_text_byte);
        n_accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (text_q.size() != 0 && !(text_q[0].drain && expect_q.size() != 0)) begin
          in_text_byte <= text_q[0].ch;
          in_valid <= 1'b1;
          void'(text_q.pop_front());
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap_left = $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver

  function automatic void field_chk(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expect_q.size() == 0) begin
          $error("unexpected result: kind %0d value %0d", out_token_kind, out_value_byte);
          errors++;
        end else begin
          want = expect_q.pop_front();
          field_chk("token_kind", 8'(want.kind), 8'(out_token_kind));
          field_chk("value_byte", want.value, out_value_byte);
          field_chk("has_byte", 8'(want.has), 8'(out_has_byte));
          field_chk("token_first", 8'(want.first), 8'(out_token_first));
          field_chk("token_last", 8'(want.last), 8'(out_token_last));
          field_chk("lex_error", 8'(want.err), 8'(out_lex_error));
          field_chk("text_done", 8'(want.done), 8'(out_text_done));
          field_chk("last_of_run", 8'(want.run_last), 8'(out_last_of_run));
          n_checked++;
          if (want.last) n_tok_ends++;
          if (want.err) n_lex_errs++;
          if (want.done) n_texts++;
        end
      end
      if (stall_left == 0) begin
        stall_pat = stall_pat_e'($urandom_range(0, 3));
        stall_left = $urandom_range(16, 96);
      end else begin
        stall_left--;
      end
      case (stall_pat)
        ST_NONE: out_stall <= 1'b0;
        ST_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        ST_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_left[2];
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("json_token_lexer_core_tb failed");
      $finish;
    end
  end

  initial begin
    put_str("[-0.5,\"a\\/\\n\"]");
    put(CH_NUL, 1);
    put_str("{7:nuX");
    put(8'hFF, 0);
    put(CH_NUL, 1);
    put_str("\"\\");
    put(CH_NUL, 1);
    drain_next = 1'b1;
    while (n_items < ITEM_TARGET) gen_text();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (n_accepted < n_total) @(posedge clk);
    while (expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d text bytes, checked %0d results over %0d texts", n_total, n_checked,
             n_texts);
    $display("tokens closed: %0d, lexing errors: %0d", n_tok_ends, n_lex_errs);
    if (errors == 0) begin
      $display("json_token_lexer_core_tb passed");
    end else begin
      $display("json_token_lexer_core_tb failed");
    end
    $finish;
  end

endmodule
